/* hw/rtl/lrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and constants of the rectangle fill byte sequencer
// Item, result, configuration and queue entry layouts, panel command codes
// and register indexes.
// ----------------------------------------------------------------------------
package lrf_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [9:0]  column_offset;
    logic [9:0]  row_offset;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic        is_tick;
    logic [15:0] col_start;
    logic [15:0] col_end;
    logic [15:0] row_start;
    logic [15:0] row_end;
    logic [10:0] fill_w;
    logic [10:0] fill_h;
    logic [15:0] color;
  } cmd_t;

  localparam logic        MODE_TICK      = 1'b1;

  localparam logic [7:0]  CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0]  CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0]  CMD_MEM_WRITE  = 8'h2C;

  localparam logic [10:0] SCREEN_MAX     = 11'd1024;

  // Header sequencer steps.
  localparam logic [3:0]  STEP_COL_CMD   = 4'd0;
  localparam logic [3:0]  STEP_ROW_CMD   = 4'd5;
  localparam logic [3:0]  STEP_MEM_CMD   = 4'd10;
  localparam logic [3:0]  PIXEL_PHASE    = 4'd11;

  localparam logic [1:0]  REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0]  REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0]  REG_ROW_OFFSET    = 2'd3;

  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd240;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd320;

endpackage

/* hw/rtl/lcd_rect_fill_byte_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer: window fill byte stream for an RGB565 panel
// Clips fill requests to the screen; each advance tick in a fill becomes one
// command or data byte: column window, row window, memory write, pixels.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_push / in_full     | in_data  (mode, rect, fill_color)
//  out     | out_pop / out_empty   | out_data (bus_byte, is_data, last)
//  cfg     | psel/penable/pwrite   | paddr[3:2] register, pwdata, prdata
//
//  One item per cycle sustained while out_pop frees the output register;
//  a byte goes via the front's queue entry, then the back's output register.
//  The rate is set by the back's one-byte-per-cycle sequencer loop.
//  The output register stalls on its own; the queue of QUEUE_DEPTH items
//  absorbs it, and in_full rises once the queue is full.
//  Synchronous active-low reset; the block is idle with an empty queue after.
// ----------------------------------------------------------------------------
module lcd_rect_fill_byte_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lrf_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output lrf_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import lrf_pkg::*;

  cfg_t cfg_r;
  logic cfg_wr;
  logic in_take;
  logic q_push;
  cmd_t q_wr_cmd;
  logic q_valid;
  cmd_t q_rd_cmd;
  logic q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.column_offset <= '0;
      cfg_r.row_offset    <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_pwdata[10:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_pwdata[10:0];
        REG_COLUMN_OFFSET: cfg_r.column_offset <= cfg_pwdata[9:0];
        REG_ROW_OFFSET:    cfg_r.row_offset    <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SCREEN_WIDTH:  cfg_prdata = {21'd0, cfg_r.screen_width};
      REG_SCREEN_HEIGHT: cfg_prdata = {21'd0, cfg_r.screen_height};
      REG_COLUMN_OFFSET: cfg_prdata = {22'd0, cfg_r.column_offset};
      REG_ROW_OFFSET:    cfg_prdata = {22'd0, cfg_r.row_offset};
      default:           cfg_prdata = '0;
    endcase
  end

  assign in_take = in_push && !in_full;

  lrf_front u_front (
    .in_item (in_data),
    .in_take (in_take),
    .cfg     (cfg_r),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  lrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (in_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  lrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_item  (out_data),
    .out_pop   (out_pop)
  );

endmodule

/* hw/rtl/lrf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_front: item classifier
// Checks fill requests against the screen, clips them and adds the panel
// offsets; ticks pass through. Dropped requests never reach the queue.
// ----------------------------------------------------------------------------
module lrf_front (
  input  lrf_pkg::in_item_t in_item,
  input  logic              in_take,
  input  lrf_pkg::cfg_t     cfg,
  output logic              q_push,
  output lrf_pkg::cmd_t     q_cmd
);
  import lrf_pkg::*;

  logic [10:0] sw;
  logic [10:0] sh;
  logic        drop;
  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic [10:0] w_clip;
  logic [10:0] h_clip;

  always_comb begin
    sw = (cfg.screen_width  > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_width;
    sh = (cfg.screen_height > SCREEN_MAX) ? SCREEN_MAX : cfg.screen_height;
    drop = (in_item.rect_x >= {5'd0, sw}) || (in_item.rect_y >= {5'd0, sh}) ||
           (in_item.rect_width == 16'd0) || (in_item.rect_height == 16'd0);
    x_sum = {1'b0, in_item.rect_x} + {1'b0, in_item.rect_width};
    y_sum = {1'b0, in_item.rect_y} + {1'b0, in_item.rect_height};
    // x < sw here, so an unclipped width already fits in 11 bits
    w_clip = (x_sum > {6'd0, sw}) ? (sw - in_item.rect_x[10:0]) : in_item.rect_width[10:0];
    h_clip = (y_sum > {6'd0, sh}) ? (sh - in_item.rect_y[10:0]) : in_item.rect_height[10:0];

    q_cmd.is_tick   = (in_item.mode == MODE_TICK);
    q_cmd.col_start = in_item.rect_x + {6'd0, cfg.column_offset};
    q_cmd.col_end   = in_item.rect_x + {5'd0, w_clip} + {6'd0, cfg.column_offset} - 16'd1;
    q_cmd.row_start = in_item.rect_y + {6'd0, cfg.row_offset};
    q_cmd.row_end   = in_item.rect_y + {5'd0, h_clip} + {6'd0, cfg.row_offset} - 16'd1;
    q_cmd.fill_w    = w_clip;
    q_cmd.fill_h    = h_clip;
    q_cmd.color     = in_item.fill_color;

    q_push = in_take && (q_cmd.is_tick || !drop);
  end

endmodule

/* hw/rtl/lrf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_queue: command queue between front and back
// Small circular buffer of classified items with a fill count.
// ----------------------------------------------------------------------------
module lrf_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  lrf_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output lrf_pkg::cmd_t rd_cmd
);
  import lrf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !(rd_en && rd_valid)) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!wr_en && rd_en && rd_valid) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en && rd_valid) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* hw/rtl/lrf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_back: byte sequencer
// Loads a fill from a request, then sends one header or pixel byte per tick
// into a one-beat output register.
// ----------------------------------------------------------------------------
module lrf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lrf_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_empty,
  output lrf_pkg::out_item_t out_item,
  input  logic               out_pop
);
  import lrf_pkg::*;

  logic        busy_r,  busy_nxt;
  logic [3:0]  step_r,  step_nxt;
  logic [15:0] words_r [4];
  logic [20:0] pixels_r, pixels_nxt;
  logic        low_r,   low_nxt;
  logic [15:0] color_r;
  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;

  logic        slot_free;
  logic        is_tick;
  logic        load;
  logic        emit;
  logic [21:0] area;
  logic [3:0]  pos;
  logic [1:0]  wsel;
  logic [15:0] word;
  logic [20:0] pix_dec;

  assign slot_free = !out_valid_r || out_pop;
  assign is_tick   = q_cmd.is_tick;
  assign load      = q_valid && !is_tick && !busy_r;
  assign emit      = q_valid && is_tick && busy_r && slot_free;
  // requests while busy and ticks while idle leave the queue with no effect
  assign q_pop     = q_valid && (!is_tick || !busy_r || slot_free);
  assign area      = q_cmd.fill_w * q_cmd.fill_h;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    pos  = (step_r < STEP_ROW_CMD) ? (step_r - 4'd1) : (step_r - 4'd6);
    wsel = {(step_r > STEP_ROW_CMD), pos[1]};
    word = words_r[wsel];
    pix_dec = (pixels_r != '0) ? (pixels_r - 21'd1) : '0;

    busy_nxt   = busy_r;
    step_nxt   = step_r;
    pixels_nxt = pixels_r;
    low_nxt    = low_r;
    out_item_nxt.bus_byte  = pos[0] ? word[7:0] : word[15:8];
    out_item_nxt.is_data   = 1'b1;
    out_item_nxt.last_byte = 1'b0;

    if (load) begin
      busy_nxt   = 1'b1;
      step_nxt   = STEP_COL_CMD;
      pixels_nxt = area[20:0];
      low_nxt    = 1'b0;
    end else if (emit) begin
      if (step_r < PIXEL_PHASE) begin
        if (step_r == STEP_COL_CMD) begin
          out_item_nxt.bus_byte = CMD_COLUMN_SET;
          out_item_nxt.is_data  = 1'b0;
        end else if (step_r == STEP_ROW_CMD) begin
          out_item_nxt.bus_byte = CMD_ROW_SET;
          out_item_nxt.is_data  = 1'b0;
        end else if (step_r == STEP_MEM_CMD) begin
          out_item_nxt.bus_byte = CMD_MEM_WRITE;
          out_item_nxt.is_data  = 1'b0;
        end
        step_nxt = step_r + 4'd1;
      end else if (!low_r) begin
        out_item_nxt.bus_byte = color_r[15:8];
        low_nxt = 1'b1;
      end else begin
        out_item_nxt.bus_byte = color_r[7:0];
        low_nxt    = 1'b0;
        pixels_nxt = pix_dec;
        if (pix_dec == '0) begin
          out_item_nxt.last_byte = 1'b1;
          busy_nxt = 1'b0;
          step_nxt = STEP_COL_CMD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_COL_CMD;
      pixels_r    <= '0;
      low_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      pixels_r <= pixels_nxt;
      low_r    <= low_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words_r[0] <= q_cmd.col_start;
      words_r[1] <= q_cmd.col_end;
      words_r[2] <= q_cmd.row_start;
      words_r[3] <= q_cmd.row_end;
      color_r    <= q_cmd.color;
    end
    if (emit) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

/* hw/rtl/lrf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_checker: port-level checks of the fill byte sequencer
// Watches the result channel for holding, reset and byte-marking rules.
// ----------------------------------------------------------------------------
module lrf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input lrf_pkg::out_item_t out_data
);
  import lrf_pkg::*;

  // hold a waiting beat until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result beat changed or vanished before pop");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.last_byte |-> out_data.is_data)
    else $error("last byte flagged on a command byte");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.is_data |->
      (out_data.bus_byte == CMD_COLUMN_SET) || (out_data.bus_byte == CMD_ROW_SET) ||
      (out_data.bus_byte == CMD_MEM_WRITE))
    else $error("command byte is not a window or memory write code");

endmodule

bind lcd_rect_fill_byte_sequencer lrf_checker u_lrf_checker (.*);

/* sim/lcd_rect_fill_byte_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer_tb: self-checking bench for the rect fill sequencer
// Pushes fill requests and advance ticks, reprograms the clip and offset
// registers between phases, and compares every popped byte with an in-bench
// model of the window header and pixel stream.
// ----------------------------------------------------------------------------
module lcd_rect_fill_byte_sequencer_tb;
  import lrf_pkg::*;

  localparam logic MODE_FILL   = ~MODE_TICK;
  localparam int   IN_BITS     = $bits(in_item_t);
  localparam int   DRAIN_PAD   = 16;
  localparam int   HOLD_CYCLES = 250;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_push     = 1'b0;
  logic        in_full;
  in_item_t    in_data     = '0;
  logic        out_empty;
  logic        out_pop     = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lcd_rect_fill_byte_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Register shadow
  logic [10:0] scr_w   = RST_SCREEN_WIDTH;
  logic [10:0] scr_h   = RST_SCREEN_HEIGHT;
  logic [9:0]  col_off = '0;
  logic [9:0]  row_off = '0;

  // Sequencer model state
  bit          fill_busy  = 1'b0;
  logic [3:0]  hdr_step   = STEP_COL_CMD;
  logic [15:0] win_word [4] = '{default: '0};
  logic [20:0] px_left    = '0;
  bit          low_next   = 1'b0;
  logic [15:0] color_held = '0;

  in_item_t  items_to_send[$];
  out_item_t bytes_due[$];

  int mismatch_cnt     = 0;
  int bytes_checked    = 0;
  int fills_started    = 0;
  int requests_skipped = 0;
  int settings_used    = 1;
  int idle_pct         = 33;
  int plan_left        = 0;   // bytes still owed by the fill the queued items run
  int stall_left       = 0;
  bit stall_done       = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int screen_lim(input logic [10:0] v);
    return (v > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(v);
  endfunction

  // Returns 0 for a request that gets dropped; clips w and h otherwise.
  function automatic bit clip_rect(input int x, input int y, inout int w, inout int h);
    int sw, sh;
    sw = screen_lim(scr_w);
    sh = screen_lim(scr_h);
    if (x >= sw || y >= sh || w == 0 || h == 0) return 1'b0;
    if (x + w > sw) w = sw - x;
    if (y + h > sh) h = sh - y;
    return 1'b1;
  endfunction

  function automatic void model_accept(input in_item_t it);
    out_item_t ob;
    int        w, h, pos, base;
    if (it.mode != MODE_TICK) begin
      w = it.rect_width;
      h = it.rect_height;
      if (fill_busy || !clip_rect(it.rect_x, it.rect_y, w, h)) begin
        requests_skipped++;
        return;
      end
      win_word[0] = 16'(int'(it.rect_x) + int'(col_off));
      win_word[1] = 16'(int'(it.rect_x) + w - 1 + int'(col_off));
      win_word[2] = 16'(int'(it.rect_y) + int'(row_off));
      win_word[3] = 16'(int'(it.rect_y) + h - 1 + int'(row_off));
      px_left     = 21'(w * h);
      color_held  = it.fill_color;
      hdr_step    = STEP_COL_CMD;
      low_next    = 1'b0;
      fill_busy   = 1'b1;
      fills_started++;
      return;
    end
    if (!fill_busy) return;
    ob.bus_byte  = '0;
    ob.is_data   = 1'b1;
    ob.last_byte = 1'b0;
    if (hdr_step < PIXEL_PHASE) begin
      case (hdr_step)
        STEP_COL_CMD: begin
          ob.bus_byte = CMD_COLUMN_SET;
          ob.is_data  = 1'b0;
        end
        STEP_ROW_CMD: begin
          ob.bus_byte = CMD_ROW_SET;
          ob.is_data  = 1'b0;
        end
        STEP_MEM_CMD: begin
          ob.bus_byte = CMD_MEM_WRITE;
          ob.is_data  = 1'b0;
        end
        default: begin
          // start word then end word, each high byte first
          base = (hdr_step < STEP_ROW_CMD) ? 0 : 2;
          pos  = int'(hdr_step) - 1 -
                 ((hdr_step < STEP_ROW_CMD) ? int'(STEP_COL_CMD) : int'(STEP_ROW_CMD));
          ob.bus_byte = pos[0] ? win_word[base + pos / 2][7:0]
                               : win_word[base + pos / 2][15:8];
        end
      endcase
      hdr_step = hdr_step + 4'd1;
    end else if (!low_next) begin
      ob.bus_byte = color_held[15:8];
      low_next    = 1'b1;
    end else begin
      ob.bus_byte = color_held[7:0];
      low_next    = 1'b0;
      if (px_left > 0) px_left = px_left - 21'd1;
      if (px_left == 0) begin
        ob.last_byte = 1'b1;
        fill_busy    = 1'b0;
        hdr_step     = STEP_COL_CMD;
      end
    end
    bytes_due.push_back(ob);
  endfunction

  function automatic void check_byte(input out_item_t got);
    out_item_t want;
    if (bytes_due.size() == 0) begin
      if (mismatch_cnt < 10)
        $display("byte %0d popped with nothing due: %02h/%0b/%0b", bytes_checked,
                 got.bus_byte, got.is_data, got.last_byte);
      mismatch_cnt++;
    end else begin
      want = bytes_due.pop_front();
      if (got.bus_byte !== want.bus_byte || got.is_data !== want.is_data ||
          got.last_byte !== want.last_byte) begin
        if (mismatch_cnt < 10)
          $display("byte %0d: expected %02h/%0b/%0b got %02h/%0b/%0b", bytes_checked,
                   want.bus_byte, want.is_data, want.last_byte,
                   got.bus_byte, got.is_data, got.last_byte);
        mismatch_cnt++;
      end
    end
    bytes_checked++;
  endfunction

  // Stimulus planning: tracks how many ticks the queued fill still needs.
  function automatic void queue_request(input int x, input int y, input int w, input int h,
                                        input logic [15:0] color);
    in_item_t it;
    int       cw, ch;
    it.mode        = MODE_FILL;
    it.rect_x      = 16'(x);
    it.rect_y      = 16'(y);
    it.rect_width  = 16'(w);
    it.rect_height = 16'(h);
    it.fill_color  = color;
    cw = w;
    ch = h;
    if (plan_left == 0 && clip_rect(x, y, cw, ch))
      plan_left = int'(PIXEL_PHASE) + 2 * cw * ch;
    items_to_send.push_back(it);
  endfunction

  function automatic void queue_ticks(input int n);
    in_item_t it;
    repeat (n) begin
      it      = IN_BITS'({$urandom, $urandom, $urandom});
      it.mode = MODE_TICK;
      if (plan_left > 0) plan_left--;
      items_to_send.push_back(it);
    end
  endfunction

  // Mostly in range and small; sometimes hugging the far edge with a huge span.
  function automatic void pick_span(input int lim, output int p, output int n);
    if (lim == 0) begin
      p = $urandom_range(65535);
      n = $urandom_range(1, 4);
    end else if ($urandom_range(3) == 0) begin
      p = lim - int'($urandom_range(1, (lim < 3) ? lim : 3));
      n = $urandom_range(65535);
    end else begin
      p = $urandom_range(lim - 1);
      n = $urandom_range(1, 4);
    end
  endfunction

  function automatic void queue_random_op();
    int x, y, w, h, kind;
    kind = $urandom_range(99);
    pick_span(screen_lim(scr_w), x, w);
    pick_span(screen_lim(scr_h), y, h);
    if (kind < 70) begin
      queue_request(x, y, w, h, 16'($urandom));
      if ($urandom_range(4) == 0 && plan_left > 1) begin
        queue_ticks($urandom_range(1, plan_left - 1));
        queue_request(y, x, h, w, 16'($urandom));
      end
      queue_ticks(plan_left);
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0:       x = $urandom_range(screen_lim(scr_w), 65535);
        1:       y = $urandom_range(screen_lim(scr_h), 65535);
        2:       w = 0;
        default: h = 0;
      endcase
      queue_request(x, y, w, h, 16'($urandom));
    end else if (kind < 90) begin
      queue_ticks($urandom_range(1, 3));
    end else begin
      // abandon the fill part way; the next request then lands while busy
      queue_request(x, y, w, h, 16'($urandom));
      queue_ticks($urandom_range(plan_left));
    end
  endfunction

  // Input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) model_accept(in_data);
      if (!in_push || !in_full) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_push <= 1'b1;
          in_data <= items_to_send.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result side; one long hold-off early on backs the block up into in_full.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_byte(out_data);
      if (!stall_done && bytes_checked >= 40) begin
        stall_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w   = val[10:0];
      REG_SCREEN_HEIGHT: scr_h   = val[10:0];
      REG_COLUMN_OFFSET: col_off = val[9:0];
      REG_ROW_OFFSET:    row_off = val[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_for_idle();
    while (items_to_send.size() != 0 || in_push || bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic run_phase(input int sw, input int sh, input int co, input int ro,
                           input int target, input int idle);
    int start, k;
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_COLUMN_OFFSET, co);
    write_reg(REG_ROW_OFFSET, ro);
    settings_used++;
    idle_pct = idle;
    start    = items_to_send.size();
    k        = 0;
    // queue ops until this phase has offered its share of items
    while (k < 6 || (int'(items_to_send.size()) - start) < target) begin
      queue_random_op();
      k++;
    end
    queue_ticks(plan_left);
    wait_for_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset geometry 240 x 320
    queue_ticks(1);                                  // tick while idle
    queue_request(0, 0, 0, 5, 16'h1234);             // zero width
    queue_request(0, 0, 5, 0, 16'h5678);             // zero height
    queue_request(240, 0, 1, 1, 16'h9ABC);           // first column off screen
    queue_request(0, 65535, 1, 1, 16'hDEF0);         // row far off screen
    queue_request(239, 319, 65535, 65535, 16'hFFFF); // clip to corner pixel
    queue_request(0, 0, 1, 1, 16'h0000);             // busy: drop
    queue_ticks(plan_left);
    wait_for_idle();

    run_phase(1024, 1024, 1023, 1023, 150, 33);
    run_phase(1, 1, 0, 0, 50, 33);
    run_phase(2047, 1025, 512, 7, 100, 0);           // saturated sizes, no idling
    run_phase(0, 0, 300, 900, 0, 33);                // zero size: everything dropped
    run_phase($urandom_range(1, 1024), $urandom_range(1, 1024),
              $urandom_range(1023), $urandom_range(1023), 150, 33);

    mismatch_cnt += bytes_due.size();
    $display("ran %0d fills and %0d dropped or ignored requests, %0d bytes checked",
             fills_started, requests_skipped, bytes_checked);
    $display("over %0d register settings incl. zero, saturated and max offset", settings_used);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lrf_pkg.sv
hw/rtl/lrf_front.sv
hw/rtl/lrf_queue.sv
hw/rtl/lrf_back.sv
hw/rtl/lcd_rect_fill_byte_sequencer.sv
hw/rtl/lrf_checker.sv
sim/lcd_rect_fill_byte_sequencer_tb.sv
